### rtl/pdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_pkg
// shared types and constants of the presence debounce table
// ----------------------------------------------------------------------------
package pdt_pkg;
  localparam int CAPACITY = 32;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] OP_PRESENT = 2'd0;
  localparam logic [1:0] OP_MARK    = 2'd1;
  localparam logic [1:0] OP_HELD    = 2'd2;
  localparam logic [1:0] OP_SWEEP   = 2'd3;

  localparam logic [1:0] EV_CONNECT    = 2'd0;
  localparam logic [1:0] EV_DISCONNECT = 2'd1;
  localparam logic [1:0] EV_DROPPED    = 2'd2;
  localparam logic [1:0] EV_DONE       = 2'd3;

  localparam logic CFG_TABLE_LIMIT    = 1'b0;
  localparam logic CFG_MISS_THRESHOLD = 1'b1;

  // one table entry as stored
  typedef struct packed {
    logic [31:0] id;
    logic        announced;
    logic        held;
    logic        seen;
    logic [7:0]  misses;
  } entry_t;
endpackage

### rtl/pdt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_ram
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module pdt_ram (
  input  logic                    clk,
  input  logic                    we,
  input  logic [pdt_pkg::IDX_W-1:0] waddr,
  input  pdt_pkg::entry_t         wdata,
  input  logic [pdt_pkg::IDX_W-1:0] raddr,
  output pdt_pkg::entry_t         rdata
);
  pdt_pkg::entry_t mem [pdt_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/presence_debounce_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// presence_debounce_table_unit
// debounced presence tracking of client ids in an ordered table
// ----------------------------------------------------------------------------
// One request is processed at a time. A sweep, and any other request with a
// nonzero client id, walks the table in an entry memory with one write port
// and one registered read port, one entry per cycle while no event waits on
// out_stall. A request is taken in an idle cycle and then passes a read
// state for the first entry, the walk and, for a connect or done event, an
// emit or done state. Present, mark and held requests stop at their entry
// and end sooner. An event that waits on out_stall holds the walk, and a
// stalled removal goes back through the read state to read its entry again.
// A sweep compacts the table in place: surviving entries are written back
// at the write pointer while removed ones are reported in table order, then
// a done event carries the count of removed entries that were not both
// announced and held. Entries live only below entry_count, so the memory
// needs no clearing after reset. Configuration writes are always taken.
module presence_debounce_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [31:0] client_id,
  input  logic        held_elsewhere,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [31:0] event_id,
  output logic [5:0]  dropped_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int IW = pdt_pkg::IDX_W;
  localparam int CW = pdt_pkg::CNT_W;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_WALK, S_EMIT, S_DONE} state_t;

  state_t          state;
  logic [5:0]      table_limit;
  logic [7:0]      miss_threshold;
  logic [CW-1:0]   entry_count;
  logic [CW-1:0]   rd_ptr;     // next address to read
  logic [CW-1:0]   wr_ptr;     // compaction write pointer
  logic [CW-1:0]   chk_ptr;    // address of data now on rdata
  logic [5:0]      drops;
  logic [1:0]      op;
  logic [31:0]     req_id;
  logic            req_held;

  // memory port
  logic            we;
  logic [IW-1:0]   waddr, raddr;
  pdt_pkg::entry_t wdata, rdata;

  pdt_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // limit clipped to capacity
  logic [CW-1:0] lim;
  always_comb begin
    if ({1'b0, table_limit} > 7'(pdt_pkg::CAPACITY)) lim = CW'(pdt_pkg::CAPACITY);
    else lim = CW'(table_limit);
  end

  // sweep evaluation of the entry on rdata
  logic [7:0] inc_miss;
  logic       survive;
  assign inc_miss = (rdata.misses == 8'hff) ? 8'hff : rdata.misses + 8'd1;
  assign survive  = rdata.seen || (inc_miss < miss_threshold);

  logic have_entry;
  assign have_entry = (chk_ptr < entry_count);

  // the event register is loaded this cycle
  logic emit;
  assign emit = out_free && (state == S_EMIT || state == S_DONE ||
                (state == S_WALK && have_entry && op == pdt_pkg::OP_SWEEP && !survive));

  always_comb begin
    we    = 1'b0;
    waddr = chk_ptr[IW-1:0];
    wdata = rdata;
    raddr = rd_ptr[IW-1:0];
    if (state == S_WALK && have_entry) begin
      if (op == pdt_pkg::OP_SWEEP) begin
        if (survive) begin
          we = 1'b1;
          waddr = wr_ptr[IW-1:0];
          wdata.seen = 1'b0;
          wdata.misses = rdata.seen ? rdata.misses : inc_miss;
        end
      end else if (rdata.id == req_id) begin
        we = 1'b1;
        case (op)
          pdt_pkg::OP_PRESENT: begin
            wdata.seen = 1'b1;
            wdata.misses = 8'd0;
          end
          pdt_pkg::OP_MARK: wdata.announced = 1'b1;
          default: wdata.held = req_held;
        endcase
      end
    end else if (state == S_WALK && op == pdt_pkg::OP_PRESENT
                 && entry_count < lim) begin
      // adoption of a new id at the end of the table
      we = 1'b1;
      waddr = entry_count[IW-1:0];
      wdata.id = req_id;
      wdata.announced = req_held;
      wdata.held = req_held;
      wdata.seen = 1'b1;
      wdata.misses = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      table_limit <= 6'd32;
      miss_threshold <= 8'd3;
      entry_count <= '0;
      out_valid <= 1'b0;
      rd_ptr <= '0; wr_ptr <= '0; chk_ptr <= '0; drops <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pdt_pkg::CFG_TABLE_LIMIT: table_limit <= cfg_data[5:0];
          default: miss_threshold <= cfg_data;
        endcase
      end
      if (emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= operation; req_id <= client_id; req_held <= held_elsewhere;
            rd_ptr <= '0; wr_ptr <= '0; drops <= '0;
            if (operation == pdt_pkg::OP_SWEEP || client_id != 32'd0) state <= S_READ;
          end
        end
        S_READ: begin
          chk_ptr <= rd_ptr;
          rd_ptr <= rd_ptr + CW'(1);
          state <= S_WALK;
        end
        S_WALK: begin
          if (!have_entry) begin
            if (op == pdt_pkg::OP_SWEEP) begin
              entry_count <= wr_ptr;
              state <= S_DONE;
            end else begin
              if (op == pdt_pkg::OP_PRESENT && entry_count < lim) begin
                entry_count <= entry_count + CW'(1);
                if (!req_held) state <= S_EMIT;
                else state <= S_IDLE;
              end else begin
                state <= S_IDLE;
              end
            end
          end else if (op == pdt_pkg::OP_SWEEP) begin
            if (survive) begin
              wr_ptr <= wr_ptr + CW'(1);
              chk_ptr <= rd_ptr; rd_ptr <= rd_ptr + CW'(1);
            end else if (out_free) begin
              event_id <= rdata.id;
              dropped_count <= '0;
              last <= 1'b0;
              if (rdata.announced && rdata.held) event_kind <= pdt_pkg::EV_DISCONNECT;
              else begin
                event_kind <= pdt_pkg::EV_DROPPED;
                drops <= drops + 6'd1;
              end
              chk_ptr <= rd_ptr; rd_ptr <= rd_ptr + CW'(1);
            end else begin
              // hold: re-read the same entry
              rd_ptr <= chk_ptr;
              state <= S_READ;
            end
          end else if (rdata.id == req_id) begin
            if (op == pdt_pkg::OP_PRESENT && !rdata.announced) state <= S_EMIT;
            else state <= S_IDLE;
          end else begin
            chk_ptr <= rd_ptr; rd_ptr <= rd_ptr + CW'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            event_kind <= pdt_pkg::EV_CONNECT;
            event_id <= req_id;
            dropped_count <= '0;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            event_kind <= pdt_pkg::EV_DONE;
            event_id <= '0;
            dropped_count <= drops;
            last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/pdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_checker
// port-level checks of the presence debounce table
// ----------------------------------------------------------------------------
module pdt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  event_kind,
  input logic [31:0] event_id,
  input logic [5:0]  dropped_count,
  input logic        last
);
  // a stalled event holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_id) && $stable(event_kind))
    else $error("stalled event changed");
  // done carries a zero id and is last
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == pdt_pkg::EV_DONE |-> last && event_id == 32'd0)
    else $error("bad done event");
  // removals are never last
  a_rm: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == pdt_pkg::EV_DISCONNECT ||
                  event_kind == pdt_pkg::EV_DROPPED) |-> !last)
    else $error("removal marked last");
  // only done carries a count
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind != pdt_pkg::EV_DONE |-> dropped_count == 6'd0)
    else $error("count on non-done event");
endmodule

bind presence_debounce_table_unit pdt_checker u_pdt_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .event_kind(event_kind), .event_id(event_id),
  .dropped_count(dropped_count), .last(last)
);
